// File: hw/rtl/mat_pkg.sv
// ----------------------------------------------------------------------------
// mat_pkg: shared definitions for the multi-turn angle tracker
// widths, scaling constants, register indexes and the sequencer state type
// ----------------------------------------------------------------------------
package mat_pkg;

   localparam int ANGLE_W         = 12;
   localparam int CPR_W           = 24;
   localparam int CNT_W           = 32;
   localparam int TENTHS_W        = 12;
   localparam int CSR_IDX_W       = 1;

   localparam int ANGLE_RANGE     = 4096;
   localparam int HALF_RANGE      = ANGLE_RANGE / 2;
   localparam int ANGLE_SHIFT     = $clog2(ANGLE_RANGE);
   localparam int TENTHS_PER_TURN = 3600;

   // signed sample difference before and after the half-turn wrap
   localparam int DELTA_W         = ANGLE_W + 2;
   // product of a count magnitude and the tenths per turn
   localparam int PROD_W          = CNT_W + TENTHS_W;
   // |count| * 3600 stays below 2^43
   localparam int DIVD_W          = 43;
   localparam int DIV_STEPS       = DIVD_W;
   localparam int STEP_W          = $clog2(DIV_STEPS + 1);
   localparam int ATEN_PROD_W     = ANGLE_W + TENTHS_W;

   localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(4096);

   localparam logic [CSR_IDX_W-1:0] CSR_COUNTS_PER_REV = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IS_CALIBRATED  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV,
      ST_FIN
   } mat_state_type;

endpackage

// File: hw/rtl/mat_if.sv
// ----------------------------------------------------------------------------
// mat channel interfaces
// valid/ready channels for angle samples and tracker results
// ----------------------------------------------------------------------------
interface mat_req_if;
   import mat_pkg::*;

   logic               valid;
   logic               ready;
   logic [ANGLE_W-1:0] raw_angle;
   logic               read_ok;

   modport source (output valid, output raw_angle, output read_ok, input ready);
   modport sink   (input valid, input raw_angle, input read_ok, output ready);
endinterface

interface mat_rsp_if;
   import mat_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [CNT_W-1:0]    total_counts;
   logic        [TENTHS_W-1:0] angle_tenths;
   logic signed [CNT_W-1:0]    real_angle_tenths;

   modport source (output valid, output total_counts, output angle_tenths,
                   output real_angle_tenths, input ready);
   modport sink   (input valid, input total_counts, input angle_tenths,
                   input real_angle_tenths, output ready);
endinterface

// File: hw/rtl/multiturn_angle_tracker_top.sv
// ----------------------------------------------------------------------------
// multiturn_angle_tracker_top: multi-turn unwrap of an absolute angle sensor
// Each request transaction carries one 12-bit angle sample and a read flag and
// gives exactly one response transaction. A good sample is differenced against
// the previous good one, the difference is wrapped into half a turn either way
// and added to a 32-bit running count; the first good sample only seeds the
// tracker and a failed read changes nothing. The response carries the count,
// the single-turn angle in tenths of a degree and the multi-turn angle in
// tenths, count * 3600 / counts_per_rev (or / 4096 when not calibrated or when
// counts_per_rev is zero), truncated toward zero, low 32 bits. A transaction
// goes from acceptance to the next possible acceptance in these steps:
// update the count, scale it by 3600, build the 43-bit quotient in the
// bit-serial restoring divider (one quotient bit per cycle), sign-correct and
// load the response register. The response register is separate from the
// divider, so a result may wait on a stalled sink while the next transaction
// is already being worked on. Configuration writes take effect on the next
// transaction and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module multiturn_angle_tracker_top (
   input  logic                            clock,
   input  logic                            reset,
   mat_req_if.sink                         req_ch,
   mat_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [mat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mat_pkg::CPR_W-1:0]       csr_wdata
);
   import mat_pkg::*;

   // sequencer
   mat_state_type             state_ff, state_in;

   // tracker state and configuration
   logic [CPR_W-1:0]          cpr_ff;
   logic                      calibrated_ff;
   logic [ANGLE_W-1:0]        prev_angle_ff, prev_angle_in;
   logic                      seeded_ff, seeded_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   // divider datapath: quotient shifts in as the dividend shifts out
   logic [DIVD_W-1:0]         quo_ff, quo_in;
   logic [CPR_W-1:0]          rem_ff, rem_in;
   logic [CPR_W-1:0]          div_ff, div_in;
   logic                      neg_ff, neg_in;
   logic [STEP_W-1:0]         step_ff, step_in;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic [TENTHS_W-1:0]       rsp_tenths_ff, rsp_tenths_in;
   logic [CNT_W-1:0]          rsp_real_ff, rsp_real_in;

   logic                      accept;
   logic signed [DELTA_W-1:0] diff;
   logic signed [DELTA_W-1:0] delta;
   logic [CNT_W-1:0]          mag;
   logic [DIVD_W-1:0]         prod;
   logic [CPR_W:0]            trial;
   logic                      fits;
   logic [ATEN_PROD_W-1:0]    aten_prod;
   logic [CNT_W-1:0]          quo_low;
   logic                      load_rsp;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // half-turn wrap of the sample difference; exactly half a turn is kept
   always_comb begin
      diff  = $signed({2'b00, req_ch.raw_angle}) - $signed({2'b00, prev_angle_ff});
      delta = diff;
      if (diff > $signed(DELTA_W'(HALF_RANGE))) begin
         delta = diff - $signed(DELTA_W'(ANGLE_RANGE));
      end else if (diff < -$signed(DELTA_W'(HALF_RANGE))) begin
         delta = diff + $signed(DELTA_W'(ANGLE_RANGE));
      end
   end

   // magnitude of the count times tenths per turn, fed to the divider
   assign mag  = count_ff[CNT_W-1] ? (~count_ff + CNT_W'(1)) : count_ff;
   assign prod = DIVD_W'(mag) * DIVD_W'(TENTHS_PER_TURN);

   // one restoring step: bring down the next dividend bit and try a subtract
   assign trial = {rem_ff, quo_ff[DIVD_W-1]};
   assign fits  = (trial >= {1'b0, div_ff});

   // single-turn angle in tenths, from the last good sample
   assign aten_prod = {{TENTHS_W{1'b0}}, prev_angle_ff} * ATEN_PROD_W'(TENTHS_PER_TURN);

   assign quo_low  = quo_ff[CNT_W-1:0];
   assign load_rsp = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in      = state_ff;
      prev_angle_in = prev_angle_ff;
      seeded_in     = seeded_ff;
      count_in      = count_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_in        = div_ff;
      neg_in        = neg_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in  = rsp_count_ff;
      rsp_tenths_in = rsp_tenths_ff;
      rsp_real_in   = rsp_real_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // failed reads leave the tracker untouched
               if (req_ch.read_ok) begin
                  if (seeded_ff) begin
                     count_in = count_ff
                              + {{(CNT_W-DELTA_W){delta[DELTA_W-1]}}, delta};
                  end
                  seeded_in     = 1'b1;
                  prev_angle_in = req_ch.raw_angle;
               end
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            quo_in  = prod;
            rem_in  = '0;
            neg_in  = count_ff[CNT_W-1];
            // fall back to the native resolution when not calibrated
            div_in  = (calibrated_ff && (cpr_ff != '0)) ? cpr_ff : CPR_W'(ANGLE_RANGE);
            step_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = fits ? CPR_W'(trial - {1'b0, div_ff}) : trial[CPR_W-1:0];
            quo_in  = {quo_ff[DIVD_W-2:0], fits};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // wait here while an earlier response is still held
            if (load_rsp) begin
               rsp_valid_in  = 1'b1;
               rsp_count_in  = count_ff;
               rsp_tenths_in = aten_prod[ANGLE_SHIFT +: TENTHS_W];
               rsp_real_in   = neg_ff ? (~quo_low + CNT_W'(1)) : quo_low;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         cpr_ff        <= CPR_RESET;
         calibrated_ff <= 1'b0;
         prev_angle_ff <= '0;
         seeded_ff     <= 1'b0;
         count_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         prev_angle_ff <= prev_angle_in;
         seeded_ff     <= seeded_in;
         count_ff      <= count_in;
         // register writes
         if (csr_we) begin
            unique case (csr_index)
               CSR_COUNTS_PER_REV: cpr_ff        <= csr_wdata;
               CSR_IS_CALIBRATED:  calibrated_ff <= csr_wdata[0];
               default:            cpr_ff        <= cpr_ff;
            endcase
         end
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_ff        <= div_in;
      neg_ff        <= neg_in;
      step_ff       <= step_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_tenths_ff <= rsp_tenths_in;
      rsp_real_ff   <= rsp_real_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.total_counts      = $signed(rsp_count_ff);
   assign rsp_ch.angle_tenths      = rsp_tenths_ff;
   assign rsp_ch.real_angle_tenths = $signed(rsp_real_ff);

   // a response only appears out of the finishing step
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the finishing step");

   // every accepted transaction goes straight to scaling
   a_accept_scale: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCALE))
      else $error("accepted transaction did not start scaling");

   // restoring divider keeps its partial remainder below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < div_ff))
      else $error("divider remainder out of range");

   // step count stays within the quotient length
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < STEP_W'(DIV_STEPS)))
      else $error("divider step count overran");

   // divisor is never zero while dividing
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_ff != '0))
      else $error("zero divisor in divider");

endmodule
